[hw/rtl/plob_pkg.sv]
package plob_pkg;

  localparam int NUM_PRICES    = 4096;
  localparam int BUCKET_LEVELS = 64;
  localparam int LEVEL_DEPTH   = 16;
  localparam int NUM_BUCKETS   = (NUM_PRICES + BUCKET_LEVELS - 1) / BUCKET_LEVELS;

  localparam int PRICE_W   = $clog2(NUM_PRICES);
  localparam int BKT_LVL_W = $clog2(BUCKET_LEVELS);
  localparam int BKT_IDX_W = $clog2(NUM_BUCKETS);
  localparam int SLOT_W    = $clog2(LEVEL_DEPTH);
  localparam int CNT_W     = SLOT_W + 1;
  localparam int BKT_CNT_W = $clog2(BUCKET_LEVELS * LEVEL_DEPTH + 1);
  localparam int ORD_AW    = PRICE_W + SLOT_W;

  localparam int ACTION_W = 2;
  localparam int QTY_W    = 20;
  localparam int POS_W    = 16;
  localparam int STATUS_W = 2;
  localparam int COST_W   = 32;

  localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CANCEL = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_BUY    = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_NOP    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_POS  = 2'd2;

endpackage

[hw/rtl/price_level_order_book_core.sv]
// One-sided limit order book with price-time priority. Each request is an add
// (append an order to its price level), a cancel by global rank (ascending
// price, then arrival) or a market buy that consumes from the lowest price up,
// and each request gives exactly one response with status, filled and cost.
// After reset the block clears its level and bucket tables, one level per
// cycle, before it takes the first request. An add reads the level and
// bucket count, then appends the order unless the level is full. A cancel
// skips whole buckets, then levels, then shifts the later orders of its level
// to close the gap. A market buy searches buckets, walks levels and fills each
// level's orders in turn. Each step uses one read port of the level, bucket
// or order memory, and one registered multiply-accumulate builds the cost.
module price_level_order_book_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic [plob_pkg::ACTION_W-1:0]  action,
  input  logic [plob_pkg::PRICE_W-1:0]   price,
  input  logic [plob_pkg::QTY_W-1:0]     quantity,
  input  logic [plob_pkg::POS_W-1:0]     position,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output logic [plob_pkg::STATUS_W-1:0]  status,
  output logic [plob_pkg::QTY_W-1:0]     filled,
  output logic [plob_pkg::COST_W-1:0]    cost
);
  import plob_pkg::*;

  typedef enum logic [18:0] {
    S_CLEAR   = 19'h00001,
    S_IDLE    = 19'h00002,
    S_ADD_RD  = 19'h00004,
    S_ADD_WR  = 19'h00008,
    S_CB_RD   = 19'h00010,
    S_CB_CMP  = 19'h00020,
    S_CL_RD   = 19'h00040,
    S_CL_CMP  = 19'h00080,
    S_CS_RD   = 19'h00100,
    S_CS_WR   = 19'h00200,
    S_CFIN    = 19'h00400,
    S_BB_RD   = 19'h00800,
    S_BB_CMP  = 19'h01000,
    S_BL_RD   = 19'h02000,
    S_BL_CHK  = 19'h04000,
    S_BO_RD   = 19'h08000,
    S_BO_FILL = 19'h10000,
    S_BL_WR   = 19'h20000,
    S_DONE    = 19'h40000
  } state_t;

  typedef struct packed {
    logic [SLOT_W-1:0] head;
    logic [CNT_W-1:0]  count;
  } level_t;

  // Storage: order slots (no reset), level head/count and bucket counts
  // (cleared by the pass after reset).
  logic [QTY_W-1:0]     ord_mem [1<<ORD_AW];
  level_t               lvl_mem [NUM_PRICES];
  logic [BKT_CNT_W-1:0] bkt_mem [NUM_BUCKETS];

  state_t state, state_next;

  logic [PRICE_W-1:0]   clr_idx;
  logic [ACTION_W-1:0]  act;
  logic [PRICE_W-1:0]   prc;
  logic [QTY_W-1:0]     want;
  logic [QTY_W-1:0]     left;
  logic [POS_W-1:0]     pos;
  logic [BKT_IDX_W-1:0] bidx;
  logic [PRICE_W-1:0]   lidx;
  logic [SLOT_W-1:0]    head;
  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     k;
  logic [BKT_CNT_W-1:0] bkt_cur;
  logic [STATUS_W-1:0]  stat;

  logic [QTY_W-1:0]     ord_rd;
  level_t               lvl_rd;
  logic [BKT_CNT_W-1:0] bkt_rd;

  logic                 ord_we, lvl_we, bkt_we;
  logic [ORD_AW-1:0]    ord_wa, ord_ra;
  logic [QTY_W-1:0]     ord_wd;
  logic [PRICE_W-1:0]   lvl_wa, lvl_ra;
  level_t               lvl_wd;
  logic [BKT_IDX_W-1:0] bkt_wa, bkt_ra;
  logic [BKT_CNT_W-1:0] bkt_wd;

  logic                 accept;
  logic [QTY_W-1:0]     fill_m;
  logic                 fill_pop;
  logic                 mac_clear, mac_start;
  logic [COST_W-1:0]    mac_sum;
  logic                 lvl_last, bkt_last;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign fill_m    = (ord_rd < left) ? ord_rd : left;
  assign fill_pop  = (ord_rd == fill_m);
  assign lvl_last  = (lidx == PRICE_W'(NUM_PRICES - 1));
  assign bkt_last  = (bidx == BKT_IDX_W'(NUM_BUCKETS - 1));
  assign mac_clear = accept;
  assign mac_start = (state == S_BO_FILL);

  plob_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .clear  (mac_clear),
    .start  (mac_start),
    .amount (fill_m),
    .price  (lidx),
    .sum    (mac_sum)
  );

  // Memory address and write selection.
  always_comb begin
    ord_we = 1'b0;
    ord_wa = {lidx, head};
    ord_wd = ord_rd - fill_m;
    ord_ra = {lidx, head};
    lvl_we = 1'b0;
    lvl_wa = lidx;
    lvl_wd = '{head: head, count: cnt};
    lvl_ra = lidx;
    bkt_we = 1'b0;
    bkt_wa = lidx[PRICE_W-1:BKT_LVL_W];
    bkt_wd = bkt_rd - BKT_CNT_W'(1);
    bkt_ra = bidx;
    case (state)
      S_CLEAR: begin
        lvl_we = 1'b1;
        lvl_wa = clr_idx;
        lvl_wd = '0;
        bkt_we = 1'b1;
        bkt_wa = clr_idx[BKT_IDX_W-1:0];
        bkt_wd = '0;
      end
      S_ADD_RD: begin
        lvl_ra = prc;
        bkt_ra = prc[PRICE_W-1:BKT_LVL_W];
      end
      S_ADD_WR: begin
        ord_we = (lvl_rd.count < CNT_W'(LEVEL_DEPTH));
        ord_wa = {prc, lvl_rd.head + lvl_rd.count[SLOT_W-1:0]};
        ord_wd = want;
        lvl_we = ord_we;
        lvl_wa = prc;
        lvl_wd = '{head: lvl_rd.head, count: lvl_rd.count + CNT_W'(1)};
        bkt_we = ord_we;
        bkt_wa = prc[PRICE_W-1:BKT_LVL_W];
        bkt_wd = bkt_rd + BKT_CNT_W'(1);
      end
      S_CS_RD: begin
        ord_ra = {lidx, head + k[SLOT_W-1:0]};
      end
      S_CS_WR: begin
        ord_we = 1'b1;
        ord_wa = {lidx, head + k[SLOT_W-1:0] - SLOT_W'(1)};
        ord_wd = ord_rd;
      end
      S_CFIN: begin
        lvl_we = 1'b1;
        lvl_wd = '{head: head, count: cnt - CNT_W'(1)};
        bkt_we = 1'b1;
        bkt_wa = bidx;
        bkt_wd = bkt_cur - BKT_CNT_W'(1);
      end
      S_BO_RD: begin
        bkt_ra = lidx[PRICE_W-1:BKT_LVL_W];
      end
      S_BO_FILL: begin
        ord_we = 1'b1;
        bkt_we = fill_pop;
      end
      S_BL_WR: begin
        lvl_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ord_we) ord_mem[ord_wa] <= ord_wd;
    if (lvl_we) lvl_mem[lvl_wa] <= lvl_wd;
    if (bkt_we) bkt_mem[bkt_wa] <= bkt_wd;
    ord_rd <= ord_mem[ord_ra];
    lvl_rd <= lvl_mem[lvl_ra];
    bkt_rd <= bkt_mem[bkt_ra];
  end

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_idx == PRICE_W'(NUM_PRICES - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (action)
            ACT_ADD:    state_next = S_ADD_RD;
            ACT_CANCEL: state_next = S_CB_RD;
            ACT_BUY:    state_next = (quantity == '0) ? S_DONE : S_BB_RD;
            default:    state_next = S_DONE;
          endcase
        end
      end
      S_ADD_RD: state_next = S_ADD_WR;
      S_ADD_WR: state_next = S_DONE;
      S_CB_RD:  state_next = S_CB_CMP;
      S_CB_CMP: begin
        if (pos < POS_W'(bkt_rd))  state_next = S_CL_RD;
        else if (bkt_last)         state_next = S_DONE;
        else                       state_next = S_CB_RD;
      end
      S_CL_RD:  state_next = S_CL_CMP;
      S_CL_CMP: begin
        if (pos < POS_W'(lvl_rd.count))                       state_next = S_CS_RD;
        else if (lidx[BKT_LVL_W-1:0] == '1 || lvl_last)       state_next = S_DONE;
        else                                                  state_next = S_CL_RD;
      end
      S_CS_RD:  state_next = (k >= cnt) ? S_CFIN : S_CS_WR;
      S_CS_WR:  state_next = S_CS_RD;
      S_CFIN:   state_next = S_DONE;
      S_BB_RD:  state_next = S_BB_CMP;
      S_BB_CMP: begin
        if (bkt_rd != '0)   state_next = S_BL_RD;
        else if (bkt_last)  state_next = S_DONE;
        else                state_next = S_BB_RD;
      end
      S_BL_RD:  state_next = S_BL_CHK;
      S_BL_CHK: begin
        if (lvl_rd.count != '0) state_next = S_BO_RD;
        else if (lvl_last)      state_next = S_DONE;
        else                    state_next = S_BL_RD;
      end
      S_BO_RD:  state_next = S_BO_FILL;
      S_BO_FILL: begin
        if (fill_pop && cnt != CNT_W'(1) && left != fill_m) state_next = S_BO_RD;
        else                                                state_next = S_BL_WR;
      end
      S_BL_WR: begin
        if (left == '0 || lvl_last) state_next = S_DONE;
        else                        state_next = S_BL_RD;
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // Sequencer: working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_idx <= clr_idx + PRICE_W'(1);
      if (state == S_DONE && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end

    case (state)
      S_IDLE: begin
        act  <= action;
        prc  <= price;
        want <= quantity;
        left <= quantity;
        pos  <= position;
        bidx <= '0;
        stat <= ST_OK;
      end
      S_ADD_WR: begin
        if (lvl_rd.count >= CNT_W'(LEVEL_DEPTH)) stat <= ST_FULL;
      end
      S_CB_CMP: begin
        // Skip whole buckets until the rank falls inside one.
        if (pos < POS_W'(bkt_rd)) begin
          lidx    <= {bidx, BKT_LVL_W'(0)};
          bkt_cur <= bkt_rd;
        end else begin
          pos  <= pos - POS_W'(bkt_rd);
          bidx <= bidx + BKT_IDX_W'(1);
          if (bkt_last) stat <= ST_BAD_POS;
        end
      end
      S_CL_CMP: begin
        if (pos < POS_W'(lvl_rd.count)) begin
          head <= lvl_rd.head;
          cnt  <= lvl_rd.count;
          k    <= pos[CNT_W-1:0] + CNT_W'(1);
        end else begin
          pos  <= pos - POS_W'(lvl_rd.count);
          lidx <= lidx + PRICE_W'(1);
          if (lidx[BKT_LVL_W-1:0] == '1 || lvl_last) stat <= ST_BAD_POS;
        end
      end
      S_CS_WR: k <= k + CNT_W'(1);
      S_BB_CMP: begin
        if (bkt_rd != '0) lidx <= {bidx, BKT_LVL_W'(0)};
        else              bidx <= bidx + BKT_IDX_W'(1);
      end
      S_BL_CHK: begin
        head <= lvl_rd.head;
        cnt  <= lvl_rd.count;
        if (lvl_rd.count == '0) lidx <= lidx + PRICE_W'(1);
      end
      S_BO_FILL: begin
        left <= left - fill_m;
        // Pop a filled order: advance the head and drop the count.
        if (fill_pop) begin
          head <= head + SLOT_W'(1);
          cnt  <= cnt - CNT_W'(1);
        end
      end
      S_BL_WR: begin
        if (left != '0) lidx <= lidx + PRICE_W'(1);
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          status <= stat;
          filled <= (act == ACT_BUY) ? (want - left) : '0;
          cost   <= (act == ACT_BUY) ? mac_sum : '0;
        end
      end
      default: begin
      end
    endcase
  end

  // No request is taken while the tables are being cleared.
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !req_ready)
    else $error("request taken during clearing pass");

  // A fill only touches a level that holds orders.
  a_fill_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_BO_FILL) |-> (cnt != '0 && left != '0))
    else $error("fill on empty level or with nothing wanted");

  // A rejected request reports no fill and no cost.
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != ST_OK) |-> (filled == '0 && cost == '0))
    else $error("rejected request reports a fill");

endmodule

[hw/rtl/plob_mac.sv]
module plob_mac (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  logic                          start,
  input  logic [plob_pkg::QTY_W-1:0]    amount,
  input  logic [plob_pkg::PRICE_W-1:0]  price,
  output logic [plob_pkg::COST_W-1:0]   sum
);
  import plob_pkg::*;

  logic [COST_W-1:0] prod;
  logic              pend;

  // Register the product, then fold it into the sum on the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= start;
    end
    if (start) begin
      prod <= COST_W'(amount * price);
    end
    if (clear) begin
      sum <= '0;
    end else if (pend) begin
      sum <= sum + prod;
    end
  end

endmodule
